FILE: src/daw_pkg.sv
// ----------------------------------------------------------------------------
// daw_pkg
// Shared types and constants of the delay-based AIMD window block.
// ----------------------------------------------------------------------------
package daw_pkg;

  localparam int HistDepthDefault = 32;
  localparam int DelayBitsDefault = 16;

  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegAdapt    = 3'd0;
  localparam logic [2:0] RegSmooth   = 3'd1;
  localparam logic [2:0] RegTarget   = 3'd2;
  localparam logic [2:0] RegRecovery = 3'd3;
  localparam logic [2:0] RegCap      = 3'd4;

  localparam logic [1:0] ModeSmooth   = 2'd0;
  localparam logic [1:0] ModeModerate = 2'd1;
  localparam logic [1:0] ModeRough    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_SCAN,
    ST_MODE,
    ST_DIV_SETUP,
    ST_DIV,
    ST_DIV_LO,
    ST_DIV_LO_RUN,
    ST_FINISH,
    ST_OUT
  } state_t;

  function automatic logic [15:0] mode_target(input logic [1:0] m);
    unique case (m)
      ModeSmooth:   mode_target = 16'd80;
      ModeModerate: mode_target = 16'd60;
      default:      mode_target = 16'd40;
    endcase
  endfunction

  function automatic logic [7:0] mode_recovery(input logic [1:0] m);
    unique case (m)
      ModeSmooth:   mode_recovery = 8'd5;
      ModeModerate: mode_recovery = 8'd3;
      default:      mode_recovery = 8'd1;
    endcase
  endfunction

endpackage

FILE: src/daw_ram.sv
// ----------------------------------------------------------------------------
// daw_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module daw_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/daw_div.sv
// ----------------------------------------------------------------------------
// daw_div
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 48-bit
// divisor, 64-bit quotient and 48-bit remainder.
// ----------------------------------------------------------------------------
module daw_div
  import daw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [47:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [47:0] remainder
);

  logic [63:0] quo;
  logic [48:0] rem;
  logic [47:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [49:0] trial;
  logic [48:0] shifted;

  assign shifted = {rem[47:0], quo[63]};
  assign trial   = {1'b0, shifted} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[49]) begin
        rem <= trial[48:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[47:0];

endmodule

FILE: src/delay_aimd_window_adaptive_target.sv
// ----------------------------------------------------------------------------
// delay_aimd_window_adaptive_target
// Delay-driven AIMD congestion window with a roughness-selected or fixed delay target.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_axis carries send and ack timestamps; each ack
// yields one result beat on m_axis with the new window in datagrams, the
// delay mode and whether the window was decreased. The delay history lives in
// a single-port RAM; once more than HISTORY_DEPTH delays have been stored,
// the roughness scan reads it one entry per cycle. The window update then
// runs through a shared one-bit-per-cycle divider: one pass for an
// increase, two passes with a setup state between for a decrease.
// One item is in work at a time: a new input beat is accepted only once
// the last one has been written back and its result is registered.
// The result sits in an output register; the next item is accepted while it
// waits, and the block stalls only when a second result would be due.
// Reset restores the registers to their defaults, the window to 1.0 and the
// mode to moderate; no clearing pass is needed. APB writes take effect at
// once and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module delay_aimd_window_adaptive_target
  import daw_pkg::*;
#(
  parameter int HISTORY_DEPTH = HistDepthDefault,
  parameter int DELAY_BITS    = DelayBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] send_time_ms, [63:32] ack_time_ms
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] window_datagrams, [17:16] mode, [18] delay_over_target
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 2);
  localparam int DB = DELAY_BITS;
  localparam int SW = 2 * DB + AW + 1;
  localparam logic [CW-1:0] HistFull = CW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LastIdx  = AW'(HISTORY_DEPTH - 1);
  localparam logic [SW-1:0] N1 = SW'(HISTORY_DEPTH - 1);

  // Configuration registers.
  logic        adapt_enable;
  logic [9:0]  decrease_smoothing;
  logic [15:0] fixed_target_ms;
  logic [7:0]  fixed_recovery;
  logic [15:0] rough_mode_cap;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      adapt_enable       <= 1'b1;
      decrease_smoothing <= 10'd100;
      fixed_target_ms    <= 16'd80;
      fixed_recovery     <= 8'd5;
      rough_mode_cap     <= 16'd5;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegAdapt:    adapt_enable       <= pwdata[0];
        RegSmooth:   decrease_smoothing <= pwdata[9:0];
        RegTarget:   fixed_target_ms    <= pwdata[15:0];
        RegRecovery: fixed_recovery     <= pwdata[7:0];
        RegCap:      rough_mode_cap     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegAdapt:    prdata = {31'd0, adapt_enable};
      RegSmooth:   prdata = {22'd0, decrease_smoothing};
      RegTarget:   prdata = {16'd0, fixed_target_ms};
      RegRecovery: prdata = {24'd0, fixed_recovery};
      RegCap:      prdata = {16'd0, rough_mode_cap};
      default:     prdata = '0;
    endcase
  end

  // Block state.
  state_t         state, state_next;
  logic [31:0]    cwnd;
  logic [AW-1:0]  hptr;
  logic [CW-1:0]  seen;
  logic [1:0]     regime;
  logic [DB-1:0]  delay;
  logic [SW-1:0]  sum;
  logic [AW-1:0]  scan_idx;
  logic [CW-1:0]  scan_cnt;
  logic [DB-1:0]  prev;
  logic           over;
  logic [63:0]    hi_part;
  logic [47:0]    dsor;

  // Result register.
  logic           out_valid;
  logic [15:0]    out_win;
  logic [1:0]     out_mode;
  logic           out_over;

  // RAM port.
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [DB-1:0]  ram_rdata;

  daw_ram #(.Width(DB), .Depth(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (delay),
    .rdata (ram_rdata)
  );

  // Divider.
  logic        div_start;
  logic [63:0] div_dividend;
  logic [47:0] div_divisor;
  logic        div_done;
  logic [63:0] div_q;
  logic [47:0] div_r;

  daw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  logic [32:0] diff;
  logic [31:0] raw_delay;
  logic        in_fire;
  logic [DB:0] rise;
  logic [2*DB-1:0] rise_sq;
  logic [SW:0] sum_add;
  logic [1:0]  mode_next;
  logic [15:0] target;
  logic [7:0]  recovery;
  logic        over_now;
  logic [32:0] m_val;
  logic [33:0] d_raw;
  logic [33:0] d_val;
  logic [64:0] t_hi;
  logic [64:0] lo_num;
  logic [64:0] q_full;
  logic [32:0] grown;
  logic [31:0] w_dec;
  logic [31:0] w_new;
  logic [15:0] cap;
  logic [31:0] capq;
  logic [15:0] win_int;

  assign raw_delay = s_axis_tdata[63:32] - s_axis_tdata[31:0];
  assign diff      = {1'b0, raw_delay};
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // Rise between the previous entry and the one just read.
  assign rise    = {1'b0, ram_rdata} - {1'b0, prev};
  assign rise_sq = rise[DB-1:0] * rise[DB-1:0];
  assign sum_add = {1'b0, sum} + {{(SW-2*DB+1){1'b0}}, rise_sq};

  always_comb begin
    mode_next = ModeModerate;
    if (sum > SW'(70) * N1) mode_next = ModeRough;
    if (regime == ModeRough && sum < SW'(40) * N1) mode_next = ModeModerate;
    if (regime == ModeSmooth && sum > SW'(50) * N1) mode_next = ModeModerate;
    if (sum < SW'(30) * N1) mode_next = ModeSmooth;
  end

  assign target   = adapt_enable ? mode_target(regime) : fixed_target_ms;
  assign recovery = adapt_enable ? mode_recovery(regime) : fixed_recovery;
  assign over_now = {16'd0, delay} > {16'd0, target};

  assign m_val = {1'b0, cwnd} + {7'd0, decrease_smoothing, 16'd0};
  assign d_raw = {1'b0, cwnd, 1'b0} + {8'd0, decrease_smoothing, 16'd0};
  assign d_val = (d_raw > {2'b0, OneQ16}) ? d_raw - {2'b0, OneQ16} : 34'd1;
  // wh*m fits in 49 bits.
  assign t_hi   = 65'({16'd0, cwnd[31:16]} * {16'd0, m_val[31:0]})
                  + (m_val[32] ? {17'd0, cwnd[31:16], 32'd0} : 65'd0);
  assign lo_num = {1'b0, div_r, 16'd0} + 65'({16'd0, cwnd[15:0]} * m_val[31:0])
                  + (m_val[32] ? {17'd0, cwnd[15:0], 32'd0} : 65'd0);
  assign q_full = {hi_part[48:0], 16'd0} + {1'b0, div_q};
  assign w_dec  = (q_full > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF :
                  (q_full < {33'd0, OneQ16}) ? OneQ16 : q_full[31:0];
  assign grown  = {1'b0, cwnd} + div_q[32:0];

  assign cap  = (rough_mode_cap == 16'd0) ? 16'd1 : rough_mode_cap;
  assign capq = {cap, 16'd0};
  assign w_new = over ? w_dec : ((div_q[63:32] != 32'd0 || grown[32]) ?
                 32'hFFFF_FFFF : grown[31:0]);
  assign win_int = (cwnd[31:16] == 16'd0) ? 16'd1 : cwnd[31:16];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_fire) state_next = (seen > HistFull) ? ST_RD0 : ST_MODE;
      ST_RD0:        state_next = ST_SCAN;
      ST_SCAN:       if (scan_cnt == '0) state_next = ST_MODE;
      ST_MODE:       state_next = ST_DIV_SETUP;
      ST_DIV_SETUP:  state_next = ST_DIV;
      ST_DIV:        if (div_done) state_next = over ? ST_DIV_LO : ST_FINISH;
      ST_DIV_LO:     state_next = ST_DIV_LO_RUN;
      ST_DIV_LO_RUN: if (div_done) state_next = ST_FINISH;
      ST_FINISH:     state_next = ST_OUT;
      ST_OUT:        if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_addr     = scan_idx;
    div_start    = 1'b0;
    div_dividend = {32'd0, recovery, 24'd0} << 8;
    div_divisor  = {16'd0, cwnd};
    unique case (state)
      ST_DIV_SETUP: begin
        div_start = 1'b1;
        if (over_now) begin
          div_dividend = t_hi[63:0];
          div_divisor  = {14'd0, d_val};
        end else begin
          div_dividend = {24'd0, recovery, 32'd0};
          div_divisor  = {16'd0, (cwnd == 32'd0) ? OneQ16 : cwnd};
        end
      end
      ST_DIV_LO: begin
        div_start    = 1'b1;
        div_dividend = lo_num[63:0];
        div_divisor  = dsor;
      end
      ST_FINISH: begin
        ram_we   = 1'b1;
        ram_addr = hptr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cwnd      <= OneQ16;
      hptr      <= '0;
      seen      <= '0;
      regime    <= ModeModerate;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MODE) regime <= mode_next;
      if (state == ST_FINISH) begin
        if (adapt_enable && regime == ModeRough && w_new > capq) cwnd <= capq;
        else cwnd <= w_new;
        hptr <= (hptr == LastIdx) ? '0 : hptr + 1'b1;
        if (seen <= HistFull) seen <= seen + 1'b1;
      end
      if (state == ST_OUT && (!out_valid || m_axis_tready)) out_valid <= 1'b1;
      else if (out_valid && m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        delay    <= (diff > {1'b0, 32'(2 ** DB - 1)}) ? '1 : raw_delay[DB-1:0];
        sum      <= '0;
        scan_idx <= hptr;
        scan_cnt <= CW'(HISTORY_DEPTH - 1);
      end
      ST_RD0: begin
        scan_idx <= (scan_idx == LastIdx) ? '0 : scan_idx + 1'b1;
      end
      ST_SCAN: begin
        // Entry at scan_idx-1 was read last cycle.
        if (scan_cnt != CW'(HISTORY_DEPTH - 1) && !rise[DB] && rise[DB-1:0] != '0) begin
          sum <= sum_add[SW] ? '1 : sum_add[SW-1:0];
        end
        prev     <= ram_rdata;
        scan_idx <= (scan_idx == LastIdx) ? '0 : scan_idx + 1'b1;
        if (scan_cnt != '0) scan_cnt <= scan_cnt - 1'b1;
      end
      ST_MODE: ;
      ST_DIV_SETUP: begin
        over <= over_now;
        dsor <= {14'd0, d_val};
      end
      ST_DIV: if (div_done) hi_part <= div_q;
      ST_FINISH: ;
      ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_win  <= win_int;
          out_mode <= regime;
          out_over <= over;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_over, out_mode, out_win};

`ifndef SYNTHESIS
  a_win_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_win != 16'd0) else $error("window result is zero");
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    regime != 2'd3) else $error("regime out of range");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
  a_cwnd_floor: assert property (@(posedge clk) disable iff (rst)
    $past(state) == ST_FINISH && $past(over) |-> cwnd >= OneQ16)
    else $error("decrease went below one");
`endif

endmodule

FILE: sim/delay_aimd_window_adaptive_target_tb.sv
// ----------------------------------------------------------------------------
// delay_aimd_window_adaptive_target_tb
// Drives ack timestamps into the delay-based AIMD window block, predicts each
// window/mode/decrease beat with a behavioral model and compares the beats
// field by field. Registers are changed between phases while the block idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module delay_aimd_window_adaptive_target_tb;
  import daw_pkg::*;

  localparam int Depth = 32;
  localparam int DelayMax = 65535;
  localparam int IdleWait = 400;
  localparam int CycleLimit = 2_000_000;

  typedef struct packed {
    logic        over;
    logic [1:0]  mode;
    logic [15:0] window;
  } ack_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Model of the block's state and registers.
  logic        cfg_adapt;
  logic [9:0]  cfg_alpha;
  logic [15:0] cfg_target;
  logic [7:0]  cfg_recovery;
  logic [15:0] cfg_cap;
  logic [31:0] win_q16;
  logic [15:0] delays [Depth];
  int          wr_ptr;
  int          acks_seen;
  logic [1:0]  cur_mode;

  ack_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit stall_long = 1'b0;
  bit send_done = 1'b0;

  delay_aimd_window_adaptive_target u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("delay_aimd_window_adaptive_target_tb failed");
      $finish;
    end
  end

  function automatic ack_result_t predict_ack(logic [31:0] snd, logic [31:0] ack);
    logic [31:0] raw;
    logic [15:0] dly, tgt, prev, cur;
    logic [7:0]  rec;
    logic [63:0] rough, m, d, q, capq;
    logic [127:0] wide;
    logic [1:0]  nxt;
    int idx;
    ack_result_t r;
    raw = ack - snd;
    dly = (raw > DelayMax) ? 16'hFFFF : raw[15:0];
    rough = 0;
    if (acks_seen > Depth) begin
      idx = wr_ptr;
      prev = delays[idx];
      for (int i = 1; i < Depth; i++) begin
        idx = (idx + 1) % Depth;
        cur = delays[idx];
        if (cur > prev) rough += 64'(cur - prev) * 64'(cur - prev);
        prev = cur;
      end
    end
    nxt = ModeModerate;
    if (rough > 70 * (Depth - 1)) nxt = ModeRough;
    if (cur_mode == ModeRough && rough < 40 * (Depth - 1)) nxt = ModeModerate;
    if (cur_mode == ModeSmooth && rough > 50 * (Depth - 1)) nxt = ModeModerate;
    if (rough < 30 * (Depth - 1)) nxt = ModeSmooth;
    cur_mode = nxt;
    if (cfg_adapt) begin
      case (cur_mode)
        ModeSmooth:   begin tgt = 80; rec = 5; end
        ModeModerate: begin tgt = 60; rec = 3; end
        default:      begin tgt = 40; rec = 1; end
      endcase
    end else begin
      tgt = cfg_target;
      rec = cfg_recovery;
    end
    r.over = dly > tgt;
    if (r.over) begin
      // Exact floor of w*(w+a)/(2w+a-1) with every term in Q16.16.
      m = 64'(win_q16) + (64'(cfg_alpha) << 16);
      d = 2 * 64'(win_q16) + (64'(cfg_alpha) << 16);
      d = (d > 64'(OneQ16)) ? d - 64'(OneQ16) : 1;
      wide = (128'(win_q16) * 128'(m)) / 128'(d);
      q = (wide > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : wide[63:0];
      if (q < 64'(OneQ16)) q = 64'(OneQ16);
      win_q16 = q[31:0];
    end else begin
      if (win_q16 == 0) win_q16 = OneQ16;
      q = 64'(win_q16) + ((64'(rec) << 32) / 64'(win_q16));
      win_q16 = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    if (cfg_adapt && cur_mode == ModeRough) begin
      capq = 64'((cfg_cap == 0) ? 16'd1 : cfg_cap) << 16;
      if (64'(win_q16) > capq) win_q16 = capq[31:0];
    end
    delays[wr_ptr] = dly;
    wr_ptr = (wr_ptr + 1) % Depth;
    if (acks_seen <= Depth) acks_seen++;
    r.window = (win_q16[31:16] == 0) ? 16'd1 : win_q16[31:16];
    r.mode = cur_mode;
    return r;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegAdapt:    cfg_adapt = val[0];
      RegSmooth:   cfg_alpha = val[9:0];
      RegTarget:   cfg_target = val[15:0];
      RegRecovery: cfg_recovery = val[7:0];
      RegCap:      cfg_cap = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  // has_known: the typed-in result is checked against the prediction too.
  task automatic send_ack(logic [31:0] snd, logic [31:0] ack,
                          bit has_known = 0, ack_result_t known = '0);
    ack_result_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
    repeat (gap) @(negedge clk);
    s_axis_tdata <= {ack, snd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    p = predict_ack(snd, ack);
    if (has_known && p != known) begin
      $error("directed row: expected %h predicted %h", known, p);
      errors++;
    end
    pending_results.push_back(p);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Receiver side.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_long) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ack_result_t act, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act = m_axis_tdata[18:0];
      if (pending_results.size() == 0) begin
        $error("result beat %h with none expected", act);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (act.window !== exp_r.window) begin
          $error("window_datagrams: expected %0d actual %0d", exp_r.window, act.window);
          errors++;
        end
        if (act.mode !== exp_r.mode) begin
          $error("mode: expected %0d actual %0d", exp_r.mode, act.mode);
          errors++;
        end
        if (act.over !== exp_r.over) begin
          $error("delay_over_target: expected %0d actual %0d", exp_r.over, act.over);
          errors++;
        end
      end
    end
  end

  // Directed rows: send time, ack time, known flag, known result.
  typedef struct {
    logic [31:0] snd;
    logic [31:0] ack;
    bit          known;
    ack_result_t res;
  } ack_row_t;

  ack_row_t directed_rows[] = '{
    // First ack after reset: mode smooth, delay 0 grows 1.0 by 5.
    '{32'd0, 32'd0, 1, '{1'b0, ModeSmooth, 16'd6}},
    '{32'd100, 32'd180, 0, '0},
    '{32'd100, 32'd181, 0, '0},
    '{32'hFFFF_FFFF, 32'd0, 0, '0},
    '{32'd0, 32'hFFFF_FFFF, 0, '0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 0, '0},
    '{32'h1234_5678, 32'h1235_5677, 0, '0},
    '{32'h1234_5678, 32'h1235_5678, 0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 0, '0},
    '{32'd7, 32'd7, 0, '0},
    '{32'd1000, 32'd1040, 0, '0},
    '{32'd1000, 32'd1041, 0, '0},
    '{32'd1000, 32'd1060, 0, '0},
    '{32'd1000, 32'd1061, 0, '0}
  };

  task automatic rough_burst(int n, int spread, int base);
    logic [31:0] s;
    for (int i = 0; i < n; i++) begin
      s = $urandom();
      send_ack(s, s + base + $urandom_range(0, spread));
    end
  endtask

  task automatic random_acks(int n);
    logic [31:0] s;
    int kind;
    for (int i = 0; i < n; i++) begin
      s = $urandom();
      kind = $urandom_range(0, 9);
      if (kind == 0) send_ack(s, $urandom());
      else if (kind < 4) send_ack(s, s + $urandom_range(0, 20));
      else if (kind < 7) send_ack(s, s + $urandom_range(20, 120));
      else send_ack(s, s + $urandom_range(0, 400));
    end
  endtask

  initial begin
    cfg_adapt = 1; cfg_alpha = 100; cfg_target = 80; cfg_recovery = 5; cfg_cap = 5;
    win_q16 = OneQ16; wr_ptr = 0; acks_seen = 0; cur_mode = ModeModerate;
    for (int i = 0; i < Depth; i++) delays[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_ack(directed_rows[i].snd, directed_rows[i].ack,
               directed_rows[i].known, directed_rows[i].res);

    // Sender pauses until every result has come.
    wait_drained();

    // Long receiver hold-off while acks keep coming.
    fork
      begin
        stall_long = 1'b1;
        repeat (2000) @(posedge clk);
        stall_long = 1'b0;
      end
      random_acks(10);
    join

    // Adaptive phase with smooth, moderate and rough delay patterns.
    rough_burst(60, 4, 10);
    rough_burst(60, 30, 20);
    rough_burst(80, 300, 0);
    rough_burst(40, 12, 30);
    random_acks(120);
    wait_drained();

    reg_write(RegCap, 32'd1);
    reg_write(RegSmooth, 32'd0);
    rough_burst(60, 300, 0);
    wait_drained();
    reg_write(RegCap, 32'hFFFF);
    reg_write(RegSmooth, 32'd1023);
    rough_burst(60, 300, 0);
    wait_drained();
    reg_write(RegCap, 32'd0);
    rough_burst(20, 300, 0);
    wait_drained();

    // Fixed-target phases.
    reg_write(RegAdapt, 32'd0);
    reg_write(RegTarget, 32'd0);
    reg_write(RegRecovery, 32'd255);
    reg_write(RegSmooth, 32'd30);
    random_acks(150);
    wait_drained();
    reg_write(RegTarget, 32'hFFFF);
    reg_write(RegRecovery, 32'd0);
    random_acks(60);
    wait_drained();
    reg_write(RegTarget, $urandom_range(0, 200));
    reg_write(RegRecovery, $urandom_range(0, 255));
    reg_write(RegSmooth, $urandom_range(0, 1023));
    random_acks(120);
    wait_drained();

    reg_write(RegAdapt, 32'd1);
    reg_write(RegSmooth, 32'd100);
    reg_write(RegCap, $urandom_range(1, 40));
    random_acks(150);
    rough_burst(60, 200, 0);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
    if (errors == 0) begin
      $display("delay_aimd_window_adaptive_target_tb passed");
    end else begin
      $display("delay_aimd_window_adaptive_target_tb failed");
    end
    $finish;
  end

endmodule
